// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the lock table rtl
// used by files that check their own logic on aclk and aresetn
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock outside reset
`define BRLT_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("brlt assertion failed");

// antecedent implies consequent in the same cycle
`define BRLT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("brlt assertion failed");

// antecedent implies consequent in the next cycle
`define BRLT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("brlt assertion failed");

`endif

// ----- hw/rtl/brlt_pkg.sv -----
// shared types and codes for the byte range lock table
// no dependencies
package brlt_pkg;

    localparam logic [30:0] BLOCK_MAX = 31'h7fff_ffff;
    localparam int IDX_W = 10;

    localparam logic [3:0] REQ_CONFLICT  = 4'd0;
    localparam logic [3:0] REQ_COVER     = 4'd1;
    localparam logic [3:0] REQ_EXACT     = 4'd2;
    localparam logic [3:0] REQ_ADD_EXACT = 4'd3;
    localparam logic [3:0] REQ_ADD_EXT   = 4'd4;
    localparam logic [3:0] REQ_ADD_RANGE = 4'd5;
    localparam logic [3:0] REQ_DEL_SLOT  = 4'd6;
    localparam logic [3:0] REQ_DEL_OWNER = 4'd7;
    localparam logic [3:0] REQ_SET_TYPE  = 4'd8;
    localparam logic [3:0] REQ_SET_RANGE = 4'd9;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BAD      = 2'd3;

    typedef struct packed {
        logic [3:0]  code;
        logic        bad;
        logic [30:0] s;
        logic [30:0] e;
        logic [7:0]  kind;
        logic [15:0] owner;
        logic [5:0]  slot;
        logic [30:0] ns;
        logic [30:0] ne;
        logic [31:0] age;
    } req_t;

    typedef struct packed {
        logic             active;
        logic             found;
        logic [5:0]       b_slot;
        logic [30:0]      b_start;
        logic [30:0]      b_end;
        logic [7:0]       b_kind;
        logic [15:0]      b_owner;
        logic [31:0]      b_dist;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic [30:0]      xs;
        logic [30:0]      xe;
        logic [6:0]       rm_cnt;
        logic             rm_any;
    } carry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        logic [30:0]      start;
        logic [30:0]      stop;
        logic [7:0]       kind;
        logic [15:0]      owner;
        logic [31:0]      age;
    } wb_t;

endpackage

// ----- hw/rtl/brlt_cell.sv -----
// one table entry of the lock table chain
// depends on brlt_pkg
module brlt_cell #(
    parameter int IDX = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  brlt_pkg::req_t  req,
    input  brlt_pkg::wb_t   wb,
    input  brlt_pkg::carry_t c_in,
    output brlt_pkg::carry_t c_out
);

    logic        valid_reg;
    logic [30:0] start_reg;
    logic [30:0] end_reg;
    logic [7:0]  kind_reg;
    logic [15:0] owner_reg;
    logic [31:0] age_reg;

    logic [31:0] age_gap;
    logic        m;
    logic        live;
    logic        slot_hit;
    logic        owner_hit;

    assign live = c_in.active && valid_reg;
    assign slot_hit = live &&
        ({{(brlt_pkg::IDX_W-6){1'b0}}, req.slot} == brlt_pkg::IDX_W'(IDX));
    assign owner_hit = live && (owner_reg == req.owner);
    assign age_gap = req.age - age_reg;

    always_comb begin
        c_out = c_in;
        m = 1'b0;
        unique case (req.code)
            brlt_pkg::REQ_CONFLICT: m = !(req.s > end_reg || req.e < start_reg);
            brlt_pkg::REQ_COVER:    m = start_reg <= req.s && end_reg >= req.e;
            brlt_pkg::REQ_EXACT:    m = start_reg == req.s && end_reg == req.e;
            default:                m = 1'b0;
        endcase
        if (live && m) begin
            if (!c_in.found ||
                (req.code == brlt_pkg::REQ_CONFLICT && age_gap < c_in.b_dist) ||
                (req.code != brlt_pkg::REQ_CONFLICT && age_gap > c_in.b_dist)) begin
                c_out.found   = 1'b1;
                c_out.b_slot  = 6'(IDX);
                c_out.b_start = start_reg;
                c_out.b_end   = end_reg;
                c_out.b_kind  = kind_reg;
                c_out.b_owner = owner_reg;
                c_out.b_dist  = age_gap;
            end
        end
        if (slot_hit && (req.code == brlt_pkg::REQ_DEL_SLOT ||
                req.code == brlt_pkg::REQ_SET_TYPE || req.code == brlt_pkg::REQ_SET_RANGE)) begin
            c_out.found   = 1'b1;
            c_out.b_slot  = 6'(IDX);
            c_out.b_start = (req.code == brlt_pkg::REQ_SET_RANGE) ? req.ns : start_reg;
            c_out.b_end   = (req.code == brlt_pkg::REQ_SET_RANGE) ? req.ne : end_reg;
            c_out.b_kind  = (req.code == brlt_pkg::REQ_SET_TYPE) ? req.kind : kind_reg;
            c_out.b_owner = owner_reg;
        end
        if (owner_hit && req.code == brlt_pkg::REQ_DEL_OWNER) begin
            c_out.rm_cnt = c_in.rm_cnt + 7'd1;
            c_out.rm_any = 1'b1;
        end
        if (c_in.active && !valid_reg && !c_in.free_found) begin
            c_out.free_found = 1'b1;
            c_out.free_idx   = brlt_pkg::IDX_W'(IDX);
        end
        if (live) begin
            if (start_reg > req.e && (start_reg - 31'd1) < c_in.xe) begin
                c_out.xe = start_reg - 31'd1;
            end
            if (end_reg < req.s && (end_reg + 31'd1) > c_in.xs) begin
                c_out.xs = end_reg + 31'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            if (owner_hit && req.code == brlt_pkg::REQ_DEL_OWNER) begin
                valid_reg <= 1'b0;
            end
            if (slot_hit && req.code == brlt_pkg::REQ_DEL_SLOT) begin
                valid_reg <= 1'b0;
            end
            if (wb.we && wb.idx == brlt_pkg::IDX_W'(IDX)) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_hit && req.code == brlt_pkg::REQ_SET_TYPE) begin
            kind_reg <= req.kind;
        end
        if (slot_hit && req.code == brlt_pkg::REQ_SET_RANGE) begin
            start_reg <= req.ns;
            end_reg   <= req.ne;
        end
        if (wb.we && wb.idx == brlt_pkg::IDX_W'(IDX)) begin
            start_reg <= wb.start;
            end_reg   <= wb.stop;
            kind_reg  <= wb.kind;
            owner_reg <= wb.owner;
            age_reg   <= wb.age;
        end
    end

endmodule

// ----- hw/rtl/byte_range_lock_table_top.sv -----
// channel  | ports            | payload
// input    | s_tvalid/tready  | s_tuser req_type, s_tdata request fields
// result   | m_tvalid/tready  | m_tuser status, m_tdata token fields
// config   | apb psel/penable | block_size_log2 at address 0
// one request at a time: accept, block calc, a pass through the cell chain with a carry
// register behind each cell, then the write-back as the result leaves the chain end
// s_tready is low from accept until the result is loaded into the output register
// a finished request waits at the chain end while the output register is full
// synchronous active-low reset empties the table and clears age_reg
// top level of the lock table, depends on brlt_pkg, brlt_cell and assert_macros.svh
`include "assert_macros.svh"
module byte_range_lock_table_top #(
    parameter int ENTRIES = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // byte_offset[47:0] byte_count[79:48] lock_kind[87:80] owner_id[103:88]
    // slot[109:104] new_start[140:110] new_end[171:141]
    input  logic [175:0] s_tdata,
    // req_type[3:0]
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit_slot[5:0] hit_start[36:6] hit_end[67:37] hit_kind[75:68]
    // hit_owner[91:76] removed_count[98:92]
    output logic [103:0] m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam brlt_pkg::carry_t CARRY_INIT = '{xe: brlt_pkg::BLOCK_MAX, default: '0};

    logic [4:0]   bsl_reg;
    logic         busy_reg;
    logic         calc_reg;
    logic [31:0]  age_reg;
    logic [3:0]   code_reg;
    logic [47:0]  off_reg;
    logic [31:0]  cnt_reg;
    logic [7:0]   kind_reg;
    logic [15:0]  owner_reg;
    logic [5:0]   slot_reg;
    logic [30:0]  ns_reg;
    logic [30:0]  ne_reg;
    logic [30:0]  s_reg;
    logic [30:0]  e_reg;
    logic         bad_reg;
    logic         m_tvalid_reg;
    logic [103:0] m_tdata_reg;
    logic [1:0]   m_tuser_reg;

    brlt_pkg::req_t   req;
    brlt_pkg::wb_t    wb;
    brlt_pkg::carry_t carry_reg [0:ENTRIES];
    brlt_pkg::carry_t cell_out  [0:ENTRIES-1];
    brlt_pkg::carry_t fin;
    logic [ENTRIES:0] active_vec;

    logic         s_accept;
    logic         fin_go;
    logic [48:0]  last_byte;
    logic [48:0]  sh_s;
    logic [48:0]  sh_e;
    logic [1:0]   r_status;
    logic [103:0] r_data;
    logic         is_ins;

    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'd0 : {27'd0, bsl_reg};
    assign s_tready = !busy_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bsl_reg <= 5'd12;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            bsl_reg <= pwdata[4:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            code_reg  <= s_tuser;
            off_reg   <= s_tdata[47:0];
            cnt_reg   <= s_tdata[79:48];
            kind_reg  <= s_tdata[87:80];
            owner_reg <= s_tdata[103:88];
            slot_reg  <= s_tdata[109:104];
            ns_reg    <= s_tdata[140:110];
            ne_reg    <= s_tdata[171:141];
        end
    end

    assign last_byte = {1'b0, off_reg} + {17'd0, cnt_reg} - 49'd1;
    assign sh_s = {1'b0, off_reg} >> bsl_reg;
    assign sh_e = last_byte >> bsl_reg;

    always_ff @(posedge aclk) begin
        if (calc_reg) begin
            s_reg   <= (|sh_s[48:31]) ? brlt_pkg::BLOCK_MAX : sh_s[30:0];
            e_reg   <= (|sh_e[48:31]) ? brlt_pkg::BLOCK_MAX : sh_e[30:0];
            bad_reg <= (code_reg > brlt_pkg::REQ_SET_RANGE) ||
                       (code_reg <= brlt_pkg::REQ_ADD_EXT && cnt_reg == 32'd0);
        end
    end

    always_comb begin
        req.code  = code_reg;
        req.bad   = bad_reg;
        req.s     = s_reg;
        req.e     = e_reg;
        req.kind  = kind_reg;
        req.owner = owner_reg;
        req.slot  = slot_reg;
        req.ns    = ns_reg;
        req.ne    = ne_reg;
        req.age   = age_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calc_reg <= 1'b0;
            busy_reg <= 1'b0;
        end else begin
            calc_reg <= s_accept;
            if (s_accept) begin
                busy_reg <= 1'b1;
            end else if (fin_go) begin
                busy_reg <= 1'b0;
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            brlt_cell #(.IDX(gi)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .req     (req),
                .wb      (wb),
                .c_in    (carry_reg[gi]),
                .c_out   (cell_out[gi])
            );
            if (gi < ENTRIES - 1) begin : g_hop
                always_ff @(posedge aclk) begin
                    if (!aresetn) begin
                        carry_reg[gi+1].active <= 1'b0;
                    end else begin
                        carry_reg[gi+1].active <= cell_out[gi].active;
                    end
                    carry_reg[gi+1][$bits(brlt_pkg::carry_t)-2:0] <=
                        cell_out[gi][$bits(brlt_pkg::carry_t)-2:0];
                end
            end
        end
        for (gi = 0; gi <= ENTRIES; gi++) begin : g_act
            assign active_vec[gi] = carry_reg[gi].active;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg[0].active <= 1'b0;
        end else begin
            carry_reg[0].active <= calc_reg;
        end
        carry_reg[0][$bits(brlt_pkg::carry_t)-2:0] <=
            CARRY_INIT[$bits(brlt_pkg::carry_t)-2:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg[ENTRIES].active <= 1'b0;
        end else if (fin_go) begin
            carry_reg[ENTRIES].active <= 1'b0;
        end else if (!carry_reg[ENTRIES].active) begin
            carry_reg[ENTRIES].active <= cell_out[ENTRIES-1].active;
        end
        if (!carry_reg[ENTRIES].active) begin
            carry_reg[ENTRIES][$bits(brlt_pkg::carry_t)-2:0] <=
                cell_out[ENTRIES-1][$bits(brlt_pkg::carry_t)-2:0];
        end
    end

    assign fin    = carry_reg[ENTRIES];
    assign fin_go = fin.active && (!m_tvalid_reg || m_tready);
    assign is_ins = code_reg == brlt_pkg::REQ_ADD_EXACT || code_reg == brlt_pkg::REQ_ADD_EXT ||
                    code_reg == brlt_pkg::REQ_ADD_RANGE;

    always_comb begin
        wb.we    = 1'b0;
        wb.idx   = fin.free_idx;
        wb.kind  = kind_reg;
        wb.owner = owner_reg;
        wb.age   = age_reg;
        wb.start = s_reg;
        wb.stop  = e_reg;
        r_status = brlt_pkg::ST_NOTFOUND;
        r_data   = '0;
        if (code_reg == brlt_pkg::REQ_ADD_EXT) begin
            wb.start = fin.xs;
            wb.stop  = fin.xe;
        end else if (code_reg == brlt_pkg::REQ_ADD_RANGE) begin
            wb.start = ns_reg;
            wb.stop  = ne_reg;
        end
        if (bad_reg) begin
            r_status = brlt_pkg::ST_BAD;
        end else if (is_ins) begin
            if (!fin.free_found) begin
                r_status = brlt_pkg::ST_FULL;
            end else begin
                wb.we    = fin_go;
                r_status = brlt_pkg::ST_OK;
                r_data   = {5'd0, 7'd0, owner_reg, kind_reg, wb.stop, wb.start,
                            fin.free_idx[5:0]};
            end
        end else if (code_reg == brlt_pkg::REQ_DEL_OWNER) begin
            r_status = fin.rm_any ? brlt_pkg::ST_OK : brlt_pkg::ST_NOTFOUND;
            r_data   = {5'd0, fin.rm_cnt, 92'd0};
        end else if (fin.found) begin
            r_status = brlt_pkg::ST_OK;
            r_data   = {5'd0, (code_reg == brlt_pkg::REQ_DEL_SLOT) ? 7'd1 : 7'd0,
                        fin.b_owner, fin.b_kind, fin.b_end, fin.b_start, fin.b_slot};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_reg      <= 32'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (wb.we) begin
                age_reg <= age_reg + 32'd1;
            end
            if (fin_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_go) begin
            m_tdata_reg <= r_data;
            m_tuser_reg <= r_status;
        end
    end

    `BRLT_ASSERT(a_one_active, $countones(active_vec) <= 1)
    `BRLT_ASSERT_IMP(a_idle_empty, !busy_reg, active_vec == '0)
    `BRLT_ASSERT_NXT(a_fin_out, fin_go, m_tvalid && busy_reg == 1'b0)
    `BRLT_ASSERT_NXT(a_accept_busy, s_accept, busy_reg && calc_reg)

endmodule

// ----- tb/byte_range_lock_table_top_test.sv -----
// self-checking bench for byte_range_lock_table_top: a scoreboard predicts every result word
// from its own copy of the lock table, with random gaps on both streams and apb config writes
// depends on brlt_pkg and byte_range_lock_table_top
`timescale 1ns / 100ps
module byte_range_lock_table_top_test;

    localparam int NSLOTS = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [3:0] REQ_UNDEF_LO = 4'd10;
    localparam logic [3:0] REQ_UNDEF_HI = 4'd15;
    localparam logic [2:0] ADDR_BLOCK_LOG2 = 3'd0;

    typedef struct {
        logic [3:0]  code;
        logic [47:0] offset;
        logic [31:0] count;
        logic [7:0]  kind;
        logic [15:0] owner;
        logic [5:0]  slot;
        logic [30:0] nstart;
        logic [30:0] nstop;
    } lock_req_t;

    typedef struct {
        logic [1:0]  status;
        logic [5:0]  slot;
        logic [30:0] start;
        logic [30:0] stop;
        logic [7:0]  kind;
        logic [15:0] owner;
        logic [6:0]  removed;
    } lock_res_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic [3:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    byte_range_lock_table_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // lock table copy
    bit          tok_valid [NSLOTS];
    logic [30:0] tok_start [NSLOTS];
    logic [30:0] tok_stop  [NSLOTS];
    logic [7:0]  tok_kind  [NSLOTS];
    logic [15:0] tok_owner [NSLOTS];
    logic [31:0] tok_age   [NSLOTS];
    logic [31:0] age_next;
    logic [4:0]  blk_log2;

    lock_res_t expected_words [$];
    int mismatches;
    int cfg_errors;
    int words_sent;
    int words_checked;
    int status_seen [4];
    int cycle_cnt;
    bit quiet;
    int hold_len;
    int hold_gen;
    int hold_ack;
    int hold_left;
    int rx_wait;

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    function automatic logic [30:0] to_block(logic [48:0] byte_addr);
        logic [48:0] b;
        b = byte_addr >> blk_log2;
        return (b > 49'(brlt_pkg::BLOCK_MAX)) ? brlt_pkg::BLOCK_MAX : b[30:0];
    endfunction

    function automatic lock_res_t lock_table_predict(lock_req_t r);
        lock_res_t o;
        logic [30:0] s, e, xs, xe;
        int best, n;
        bit m;
        o = '{status: brlt_pkg::ST_NOTFOUND, default: '0};
        s = '0;
        e = '0;
        best = -1;
        if (r.code > brlt_pkg::REQ_SET_RANGE) begin
            o.status = brlt_pkg::ST_BAD;
            return o;
        end
        if (r.code <= brlt_pkg::REQ_ADD_EXT) begin
            if (r.count == 0) begin
                o.status = brlt_pkg::ST_BAD;
                return o;
            end
            s = to_block({1'b0, r.offset});
            e = to_block({1'b0, r.offset} + {17'd0, r.count} - 49'd1);
        end
        case (r.code)
            brlt_pkg::REQ_CONFLICT, brlt_pkg::REQ_COVER, brlt_pkg::REQ_EXACT: begin
                for (int i = 0; i < NSLOTS; i++) begin
                    if (!tok_valid[i]) continue;
                    if (r.code == brlt_pkg::REQ_CONFLICT)
                        m = !(s > tok_stop[i] || e < tok_start[i]);
                    else if (r.code == brlt_pkg::REQ_COVER)
                        m = tok_start[i] <= s && tok_stop[i] >= e;
                    else
                        m = tok_start[i] == s && tok_stop[i] == e;
                    if (!m) continue;
                    if (best < 0 ||
                        (r.code == brlt_pkg::REQ_CONFLICT &&
                         age_next - tok_age[i] < age_next - tok_age[best]) ||
                        (r.code != brlt_pkg::REQ_CONFLICT &&
                         age_next - tok_age[i] > age_next - tok_age[best]))
                        best = i;
                end
            end
            brlt_pkg::REQ_ADD_EXACT, brlt_pkg::REQ_ADD_EXT, brlt_pkg::REQ_ADD_RANGE: begin
                for (int i = NSLOTS - 1; i >= 0; i--)
                    if (!tok_valid[i]) best = i;
                if (best < 0) begin
                    o.status = brlt_pkg::ST_FULL;
                    return o;
                end
                if (r.code == brlt_pkg::REQ_ADD_EXT) begin
                    xs = '0;
                    xe = brlt_pkg::BLOCK_MAX;
                    for (int i = 0; i < NSLOTS; i++) begin
                        if (!tok_valid[i]) continue;
                        if (tok_start[i] > e && tok_start[i] - 31'd1 < xe)
                            xe = tok_start[i] - 31'd1;
                        if (tok_stop[i] < s && tok_stop[i] + 31'd1 > xs)
                            xs = tok_stop[i] + 31'd1;
                    end
                    s = xs;
                    e = xe;
                end else if (r.code == brlt_pkg::REQ_ADD_RANGE) begin
                    s = r.nstart;
                    e = r.nstop;
                end
                tok_valid[best] = 1'b1;
                tok_start[best] = s;
                tok_stop[best] = e;
                tok_kind[best] = r.kind;
                tok_owner[best] = r.owner;
                tok_age[best] = age_next;
                age_next++;
            end
            brlt_pkg::REQ_DEL_SLOT: begin
                if (tok_valid[r.slot]) begin
                    best = r.slot;
                    tok_valid[r.slot] = 1'b0;
                    o.removed = 7'd1;
                end
            end
            brlt_pkg::REQ_DEL_OWNER: begin
                n = 0;
                for (int i = 0; i < NSLOTS; i++)
                    if (tok_valid[i] && tok_owner[i] == r.owner) begin
                        tok_valid[i] = 1'b0;
                        n++;
                    end
                o.removed = 7'(n);
                o.status = (n > 0) ? brlt_pkg::ST_OK : brlt_pkg::ST_NOTFOUND;
            end
            default: begin
                if (tok_valid[r.slot]) begin
                    best = r.slot;
                    if (r.code == brlt_pkg::REQ_SET_TYPE) begin
                        tok_kind[best] = r.kind;
                    end else begin
                        tok_start[best] = r.nstart;
                        tok_stop[best] = r.nstop;
                    end
                end
            end
        endcase
        if (best >= 0) begin
            o.status = brlt_pkg::ST_OK;
            o.slot = 6'(best);
            o.start = tok_start[best];
            o.stop = tok_stop[best];
            o.kind = tok_kind[best];
            o.owner = tok_owner[best];
        end
        return o;
    endfunction

    task automatic send_word(lock_req_t r);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.code;
        s_tdata <= {4'd0, r.nstop, r.nstart, r.slot, r.owner, r.kind, r.count, r.offset};
        do @(posedge aclk); while (!s_tready);
        expected_words.push_back(lock_table_predict(r));
        words_sent++;
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic mismatch(string field, logic [47:0] exp_v, logic [47:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("word %0d %s: expected %0h got %0h", words_checked, field, exp_v, act_v);
    endtask

    task automatic set_block_log2(logic [4:0] v);
        s_tvalid <= 1'b0;
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_BLOCK_LOG2;
        pwdata <= {27'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        blk_log2 = v;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[4:0] !== v) begin
            cfg_errors++;
            $display("block_size_log2 readback: expected %0h got %0h", v, prdata[4:0]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic lock_req_t mk(logic [3:0] code, logic [47:0] off, logic [31:0] cnt,
                                     logic [7:0] kind, logic [15:0] owner, logic [5:0] slot,
                                     logic [30:0] ns, logic [30:0] ne);
        lock_req_t r;
        r.code = code;
        r.offset = off;
        r.count = cnt;
        r.kind = kind;
        r.owner = owner;
        r.slot = slot;
        r.nstart = ns;
        r.nstop = ne;
        return r;
    endfunction

    function automatic lock_req_t random_word();
        lock_req_t r;
        int pick;
        int used [$];
        pick = $urandom_range(0, 99);
        r.code = pick < 14 ? brlt_pkg::REQ_CONFLICT : pick < 24 ? brlt_pkg::REQ_COVER :
                 pick < 32 ? brlt_pkg::REQ_EXACT : pick < 47 ? brlt_pkg::REQ_ADD_EXACT :
                 pick < 57 ? brlt_pkg::REQ_ADD_EXT : pick < 65 ? brlt_pkg::REQ_ADD_RANGE :
                 pick < 75 ? brlt_pkg::REQ_DEL_SLOT : pick < 80 ? brlt_pkg::REQ_DEL_OWNER :
                 pick < 87 ? brlt_pkg::REQ_SET_TYPE : pick < 96 ? brlt_pkg::REQ_SET_RANGE :
                 4'($urandom_range(REQ_UNDEF_LO, REQ_UNDEF_HI));
        if ($urandom_range(0, 9) == 0)
            r.offset = {$urandom, $urandom};
        else
            r.offset = 48'($urandom_range(0, 63)) << blk_log2;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            r.count = '0;
        else if (pick < 12)
            r.count = $urandom;
        else
            r.count = 32'(($urandom_range(1, 4) << blk_log2) - $urandom_range(0, 1));
        if (r.count == 0 && pick >= 4) r.count = 32'd1;
        r.kind = 8'($urandom);
        r.owner = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
        for (int i = 0; i < NSLOTS; i++) if (tok_valid[i]) used.push_back(i);
        if (used.size() != 0 && $urandom_range(0, 9) < 7)
            r.slot = 6'(used[$urandom_range(0, used.size() - 1)]);
        else
            r.slot = 6'($urandom);
        r.nstart = ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 70));
        r.nstop = ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 70));
        return r;
    endfunction

    // result side stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait <= 0;
            hold_left <= 0;
            hold_ack <= 0;
        end else if (hold_gen != hold_ack) begin
            m_tready <= 1'b0;
            hold_left <= hold_len;
            hold_ack <= hold_gen;
        end else if (hold_left > 0) begin
            m_tready <= (hold_left == 1);
            hold_left <= hold_left - 1;
        end else if (m_tvalid && m_tready) begin
            rx_wait <= quiet ? 0 : $urandom_range(0, 7);
            m_tready <= quiet;
        end else if (rx_wait > 0) begin
            m_tready <= (rx_wait == 1);
            rx_wait <= rx_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        lock_res_t x;
        if (aresetn && m_tvalid && m_tready) begin
            status_seen[m_tuser]++;
            if (expected_words.size() == 0) begin
                mismatch("unexpected word", '0, 48'(m_tdata));
            end else begin
                x = expected_words.pop_front();
                if (m_tuser !== x.status) mismatch("status", 48'(x.status), 48'(m_tuser));
                if (m_tdata[5:0] !== x.slot) mismatch("hit_slot", 48'(x.slot), 48'(m_tdata[5:0]));
                if (m_tdata[36:6] !== x.start)
                    mismatch("hit_start", 48'(x.start), 48'(m_tdata[36:6]));
                if (m_tdata[67:37] !== x.stop)
                    mismatch("hit_end", 48'(x.stop), 48'(m_tdata[67:37]));
                if (m_tdata[75:68] !== x.kind)
                    mismatch("hit_kind", 48'(x.kind), 48'(m_tdata[75:68]));
                if (m_tdata[91:76] !== x.owner)
                    mismatch("hit_owner", 48'(x.owner), 48'(m_tdata[91:76]));
                if (m_tdata[98:92] !== x.removed)
                    mismatch("removed_count", 48'(x.removed), 48'(m_tdata[98:92]));
            end
            words_checked++;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_directed();
        send_word(mk(brlt_pkg::REQ_CONFLICT, 48'd0, 32'd1, 8'd0, 16'd0, 6'd0, 31'd0, 31'd0));
        send_word(mk(brlt_pkg::REQ_ADD_EXACT, 48'd4096, 32'd0, 8'd1, 16'd1, 6'd0,
                     31'd0, 31'd0));
        send_word(mk(REQ_UNDEF_LO, 48'd0, 32'd1, 8'd0, 16'd0, 6'd0, 31'd0, 31'd0));
        send_word(mk(REQ_UNDEF_HI, '1, '1, '1, '1, '1,
                     brlt_pkg::BLOCK_MAX, brlt_pkg::BLOCK_MAX));
        send_word(mk(brlt_pkg::REQ_ADD_EXACT, 48'd0, 32'd1, 8'hff, 16'hffff, 6'd0,
                     31'd0, 31'd0));
        send_word(mk(brlt_pkg::REQ_ADD_EXACT, '1, '1, 8'h00, 16'h0000, 6'd0, 31'd0, 31'd0));
        send_word(mk(brlt_pkg::REQ_ADD_RANGE, 48'd0, 32'd0, 8'h5a, 16'd3, 6'd0,
                     31'd40, 31'd20));
        send_word(mk(brlt_pkg::REQ_ADD_RANGE, 48'd0, 32'd0, 8'ha5, 16'd3, 6'd0,
                     31'd100, 31'd200));
        send_word(mk(brlt_pkg::REQ_ADD_EXT, 48'd300 << 12, 32'd4096, 8'd7, 16'd4, 6'd0,
                     31'd0, 31'd0));
        send_word(mk(brlt_pkg::REQ_ADD_EXT, 48'd50 << 12, 32'd4096, 8'd8, 16'd4, 6'd0,
                     31'd0, 31'd0));
        send_word(mk(brlt_pkg::REQ_CONFLICT, 48'd150 << 12, 32'd4096, 8'd0, 16'd0, 6'd0,
                     31'd0, 31'd0));
        send_word(mk(brlt_pkg::REQ_COVER, 48'd120 << 12, 32'd8192, 8'd0, 16'd0, 6'd0,
                     31'd0, 31'd0));
        send_word(mk(brlt_pkg::REQ_EXACT, 48'd0, 32'd4096, 8'd0, 16'd0, 6'd0, 31'd0, 31'd0));
        send_word(mk(brlt_pkg::REQ_EXACT, 48'd0, 32'd1, 8'd0, 16'd0, 6'd0, 31'd0, 31'd0));
        send_word(mk(brlt_pkg::REQ_SET_TYPE, 48'd0, 32'd0, 8'h3c, 16'd0, 6'd0,
                     31'd0, 31'd0));
        send_word(mk(brlt_pkg::REQ_SET_RANGE, 48'd0, 32'd0, 8'd0, 16'd0, 6'd1,
                     brlt_pkg::BLOCK_MAX, 31'd0));
        send_word(mk(brlt_pkg::REQ_SET_TYPE, 48'd0, 32'd0, 8'd1, 16'd0, 6'd63,
                     31'd0, 31'd0));
        send_word(mk(brlt_pkg::REQ_DEL_SLOT, 48'd0, 32'd0, 8'd0, 16'd0, 6'd63,
                     31'd0, 31'd0));
        send_word(mk(brlt_pkg::REQ_DEL_SLOT, 48'd0, 32'd0, 8'd0, 16'd0, 6'd0, 31'd0, 31'd0));
        send_word(mk(brlt_pkg::REQ_DEL_OWNER, 48'd0, 32'd0, 8'd0, 16'd999, 6'd0,
                     31'd0, 31'd0));
        send_word(mk(brlt_pkg::REQ_DEL_OWNER, 48'd0, 32'd0, 8'd0, 16'd4, 6'd0,
                     31'd0, 31'd0));
        send_word(mk(brlt_pkg::REQ_SET_RANGE, 48'd0, 32'd0, 8'd0, 16'd0, 6'd9,
                     31'd1, 31'd2));
        stop_sending();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < NSLOTS + 2; i++)
            send_word(mk(brlt_pkg::REQ_ADD_RANGE, 48'd0, 32'd0, 8'(i), 16'd77, 6'd0,
                         31'(i), 31'(i)));
        send_word(mk(brlt_pkg::REQ_ADD_EXACT, 48'd0, 32'd1, 8'd0, 16'd0, 6'd0, 31'd0, 31'd0));
        send_word(mk(brlt_pkg::REQ_DEL_OWNER, 48'd0, 32'd0, 8'd0, 16'd77, 6'd0,
                     31'd0, 31'd0));
        stop_sending();
    endtask

    task automatic test_random_traffic(int n, logic [4:0] log2v, bit no_gaps);
        set_block_log2(log2v);
        quiet = no_gaps;
        for (int i = 0; i < n; i++) send_word(random_word());
        stop_sending();
        quiet = 1'b0;
    endtask

    task automatic test_output_stall();
        hold_len = 300;
        hold_gen++;
        quiet = 1'b1;
        for (int i = 0; i < 30; i++) send_word(random_word());
        stop_sending();
        quiet = 1'b0;
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        quiet = 1'b0;
        hold_len = 0;
        hold_gen = 0;
        blk_log2 = 5'd12;
        age_next = '0;
        for (int i = 0; i < NSLOTS; i++) tok_valid[i] = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_table_full();
        test_random_traffic(150, 5'd0, 1'b0);
        test_random_traffic(130, 5'd3, 1'b1);
        test_random_traffic(140, 5'd30, 1'b0);
        test_random_traffic(120, 5'd31, 1'b0);
        test_output_stall();
        test_random_traffic(150, 5'd1, 1'b0);
        test_random_traffic(130, 5'd12, 1'b0);
        wait_drained();
        repeat (80) @(posedge aclk);
        $display("%0d requests sent, %0d result words checked over six block sizes",
                 words_sent, words_checked);
        $display("status ok %0d, not found %0d, full %0d, bad %0d, mismatches %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], mismatches);
        if (mismatches == 0 && cfg_errors == 0 && expected_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
